// ----- sv/hprf_pkg.sv -----
// Shared types, constants and saturating Q32.32 helpers for the Halley root finder.
// No dependencies.
package hprf_pkg;

    localparam int DEGREE_DEF = 4;
    localparam int NUM_COEF   = 5;
    localparam int CIDX_W     = 3;
    localparam int TOL_W      = 33;
    localparam int ITER_W     = 16;

    localparam logic [63:0] Q_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN        = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DIVERGE_LIM  = 64'd429496729600000000;

    localparam logic [1:0] ST_ROOT    = 2'd0;
    localparam logic [1:0] ST_FLAT    = 2'd1;
    localparam logic [1:0] ST_DIVERGE = 2'd2;
    localparam logic [1:0] ST_LIMIT   = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_TOL   = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_MAXIT = 3'd6;

    typedef logic [63:0] q_t;

    typedef struct packed {
        logic start;
        q_t   a;
        q_t   b;
    } op_req_t;

    function automatic q_t mag(input q_t v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic q_t from_mag(input logic neg, input q_t m, input logic ovf);
        if (neg)
            from_mag = (ovf || m[63]) ? Q_MIN : (64'd0 - m);
        else
            from_mag = (ovf || m[63]) ? Q_MAX : m;
    endfunction

    function automatic q_t sat_add(input q_t a, input q_t b);
        q_t r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            sat_add = a[63] ? Q_MIN : Q_MAX;
        else
            sat_add = r;
    endfunction

    function automatic q_t sat_sub(input q_t a, input q_t b);
        q_t r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
            sat_sub = a[63] ? Q_MIN : Q_MAX;
        else
            sat_sub = r;
    endfunction

    // a times a small count (0..7), saturating; same as repeated saturating adds
    function automatic q_t sat_small(input q_t a, input logic [2:0] n);
        logic signed [66:0] p;
        p = signed'({{3{a[63]}}, a}) * signed'({64'd0, n});
        if (p[66:63] == 4'b0000 || p[66:63] == 4'b1111)
            sat_small = p[63:0];
        else
            sat_small = p[66] ? Q_MIN : Q_MAX;
    endfunction

endpackage

// ----- sv/hprf_mul.sv -----
// Shared saturating Q32.32 multiplier: one 32x32 partial product per cycle.
// Depends on hprf_pkg.
module hprf_mul
    import hprf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  op_req_t req,
    output logic    done,
    output q_t      result
);

    q_t           ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   cnt_reg;
    logic         run_reg, done_reg;
    logic [63:0]  pp;
    logic [31:0]  opa, opb;

    assign opa = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign opb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp  = opa * opb;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    acc_next = acc_reg + {64'd0, pp};
            2'd3:    acc_next = acc_reg + {pp, 64'd0};
            default: acc_next = acc_reg + {32'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg  <= mag(req.a);
            mb_reg  <= mag(req.b);
            neg_reg <= req.a[63] ^ req.b[63];
            acc_reg <= '0;
        end
        else if (run_reg)
            acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = from_mag(neg_reg, acc_reg[95:32], |acc_reg[127:96]);

endmodule

// ----- sv/hprf_div.sv -----
// Radix-2 restoring divider for (n * 2^32) / d, saturating, one bit per cycle.
// Depends on hprf_pkg.
module hprf_div
    import hprf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  op_req_t req,
    output logic    done,
    output q_t      result
);

    localparam int STEPS = 96;
    localparam int CNT_W = $clog2(STEPS);

    logic [95:0]      dvd_reg;
    q_t               md_reg, rem_reg, q_reg;
    logic             ovf_reg, neg_reg, run_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    q_t               rs;
    logic             take;

    assign rs   = {rem_reg[62:0], dvd_reg[95]};
    assign take = rem_reg[63] || (rs >= md_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= {mag(req.a), 32'd0};
            md_reg  <= mag(req.b);
            neg_reg <= req.a[63] ^ req.b[63];
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[94:0], 1'b0};
            if (q_reg[63])
                ovf_reg <= 1'b1;
            rem_reg <= take ? (rs - md_reg) : rs;
            q_reg   <= {q_reg[62:0], take};
        end
    end

    assign done   = done_reg;
    assign result = from_mag(neg_reg, q_reg, ovf_reg);

endmodule

// ----- sv/halley_polynomial_root_finder_core.sv -----
// Halley polynomial root finder: sequencer, register file and output stage.
// Depends on hprf_pkg, hprf_mul, hprf_div.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the registers: index 0..4 are
//   the coefficients (0 highest degree), 5 the tolerance, 6 the step limit.
//   cfg_ready is always high; write only while the core is idle.
//   s_* carries one start point per beat. m_* returns one result beat per
//   start point: status, final root (zero unless a root was found) and the
//   number of Halley steps taken.
// Timing:
//   One start point at a time; s_tready is high only while the sequencer idles.
//   Each multiply runs as issue, 4 partial products and collect; a step runs
//   3*DEGREE of them (Horner for P, P', P'' plus P'^2, P*P'', P*P'), a load and
//   a finish state per polynomial and then the divide, all on one shared
//   multiplier and one shared divider. A too-small denominator ends the run
//   after P*P'', before the divide. s_tready rises with the edge that writes the
//   result. The result register holds a finished beat while the next start
//   point is taken; if m_tready stays low the next run waits before writing its
//   result.
// Reset: coefficients return to x^DEGREE (coef 0 = 1.0), tolerance 4295,
//   step limit 1000; no result is pending.
module halley_polynomial_root_finder_core
    import hprf_pkg::*;
#(
    parameter int DEGREE = DEGREE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [63:0] start_point
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [87:0]       m_tdata    // [1:0] status, [65:2] root, [81:66] iterations_used
);

    localparam logic [CIDX_W-1:0] LEN0 = CIDX_W'(DEGREE + 1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_PREP1  = 14'b00000000000010,
        S_PREP2  = 14'b00000000000100,
        S_LOAD   = 14'b00000000001000,
        S_HORN   = 14'b00000000010000,
        S_HORN_W = 14'b00000000100000,
        S_SQ     = 14'b00000001000000,
        S_SQ_W   = 14'b00000010000000,
        S_PP2    = 14'b00000100000000,
        S_PP2_W  = 14'b00001000000000,
        S_PP1    = 14'b00010000000000,
        S_PP1_W  = 14'b00100000000000,
        S_DIV_W  = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    q_t               coef_reg [NUM_COEF];
    q_t               d1_reg   [NUM_COEF];
    q_t               d2_reg   [NUM_COEF];
    logic [TOL_W-1:0] tol_reg;
    logic [ITER_W-1:0] maxit_reg;

    q_t                x_reg, r_reg, p_reg, p1_reg, p2_reg, sq_reg, den_reg;
    logic [ITER_W-1:0] k_reg;
    logic [1:0]        ps_reg;
    logic [CIDX_W-1:0] idx_reg;
    logic [1:0]        st_reg;
    q_t                root_reg;

    logic              m_valid_reg;
    logic [87:0]       m_data_reg;

    op_req_t mul_req, div_req;
    logic    mul_done, div_done;
    q_t      mul_res, div_res;

    logic [CIDX_W-1:0] len;
    q_t                cval;
    q_t                den_new, x_new, md;
    logic [ITER_W-1:0] k_new;

    hprf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .done(mul_done), .result(mul_res));
    hprf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .result(div_res));

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign len = LEN0 - {1'b0, ps_reg};

    always_comb
    begin
        case (ps_reg)
            2'd0:    cval = coef_reg[idx_reg];
            2'd1:    cval = d1_reg[idx_reg];
            default: cval = d2_reg[idx_reg];
        endcase
    end

    assign den_new = sat_sub(sat_add(sq_reg, sq_reg), mul_res);
    assign x_new   = sat_sub(x_reg, div_res);
    assign md      = mag(div_res);
    assign k_new   = k_reg + 1'b1;

    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = r_reg;
        mul_req.b     = x_reg;
        case (state_reg)
            S_HORN:  mul_req.start = (idx_reg != len);
            S_SQ:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = p1_reg;
                mul_req.b     = p1_reg;
            end
            S_PP2:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = p_reg;
                mul_req.b     = p2_reg;
            end
            S_PP1:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = p_reg;
                mul_req.b     = p1_reg;
            end
            default: mul_req.start = 1'b0;
        endcase
        div_req.start = (state_reg == S_PP1_W) && mul_done;
        div_req.a     = sat_add(mul_res, mul_res);
        div_req.b     = den_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_PREP1;
            S_PREP1:  state_next = S_PREP2;
            S_PREP2:  state_next = (maxit_reg == '0) ? S_OUT : S_LOAD;
            S_LOAD:   state_next = S_HORN;
            S_HORN:
            begin
                if (idx_reg != len)
                    state_next = S_HORN_W;
                else if (ps_reg == 2'd2)
                    state_next = S_SQ;
                else
                    state_next = S_LOAD;
            end
            S_HORN_W: if (mul_done) state_next = S_HORN;
            S_SQ:     state_next = S_SQ_W;
            S_SQ_W:   if (mul_done) state_next = S_PP2;
            S_PP2:    state_next = S_PP2_W;
            S_PP2_W:
            begin
                if (mul_done)
                begin
                    if (den_new == '0 || mag(den_new) < {31'd0, tol_reg})
                        state_next = S_OUT;
                    else
                        state_next = S_PP1;
                end
            end
            S_PP1:    state_next = S_PP1_W;
            S_PP1_W:  if (mul_done) state_next = S_DIV_W;
            S_DIV_W:
            begin
                if (div_done)
                begin
                    if (md < {31'd0, tol_reg} || md > DIVERGE_LIM || k_new == maxit_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_LOAD;
                end
            end
            S_OUT:    if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= (i == 0) ? 64'h0000_0001_0000_0000 : 64'd0;
            tol_reg     <= TOL_W'(4295);
            maxit_reg   <= ITER_W'(1000);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index < CIDX_W'(NUM_COEF))
                    coef_reg[cfg_index] <= cfg_data;
                else if (cfg_index == CFG_TOL)
                    tol_reg <= cfg_data[TOL_W-1:0];
                else if (cfg_index == CFG_MAXIT)
                    maxit_reg <= cfg_data[ITER_W-1:0];
            end
            if (state_reg == S_OUT && (!m_valid_reg || m_tready))
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg    <= s_tdata;
                k_reg    <= '0;
                st_reg   <= ST_LIMIT;
                root_reg <= '0;
                ps_reg   <= 2'd0;
                idx_reg  <= '0;
            end
            S_PREP1:
            begin
                for (int i = 0; i < NUM_COEF; i++)
                    d1_reg[i] <= (i < DEGREE) ? sat_small(coef_reg[i], 3'(DEGREE - i)) : '0;
            end
            S_PREP2:
            begin
                for (int i = 0; i < NUM_COEF; i++)
                    d2_reg[i] <= (i < DEGREE - 1) ?
                                 sat_small(d1_reg[i], 3'(DEGREE - 1 - i)) : '0;
            end
            S_LOAD:
            begin
                // an empty polynomial (second derivative at degree one) is 0
                r_reg   <= (len == '0) ? '0 : cval;
                idx_reg <= (len == '0) ? '0 : CIDX_W'(1);
            end
            S_HORN:
            begin
                if (idx_reg == len)
                begin
                    case (ps_reg)
                        2'd0:    p_reg  <= r_reg;
                        2'd1:    p1_reg <= r_reg;
                        default: p2_reg <= r_reg;
                    endcase
                    ps_reg  <= (ps_reg == 2'd2) ? 2'd0 : ps_reg + 2'd1;
                    // next load reads the leading coefficient
                    idx_reg <= '0;
                end
            end
            S_HORN_W:
            begin
                if (mul_done)
                begin
                    r_reg   <= sat_add(mul_res, cval);
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_SQ_W:  if (mul_done) sq_reg <= mul_res;
            S_PP2_W:
            begin
                if (mul_done)
                begin
                    den_reg <= den_new;
                    st_reg  <= ST_FLAT;
                end
            end
            S_DIV_W:
            begin
                if (div_done)
                begin
                    x_reg <= x_new;
                    k_reg <= k_new;
                    if (md < {31'd0, tol_reg})
                    begin
                        st_reg   <= ST_ROOT;
                        root_reg <= x_new;
                    end
                    else if (md > DIVERGE_LIM)
                        st_reg <= ST_DIVERGE;
                    else
                        st_reg <= ST_LIMIT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                    m_data_reg <= {6'd0, k_reg, root_reg, st_reg};
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/hprf_checker.sv -----
// Port-level checks for the Halley root finder core, bound to the top level.
// Depends on hprf_pkg and halley_polynomial_root_finder_core.
module hprf_checker
    import hprf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("start point taken while a run is active");

    a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_ROOT |-> m_tdata[65:2] == 64'd0)
        else $error("root nonzero without a found root");

    a_steps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_ROOT || m_tdata[1:0] == ST_DIVERGE)
        |-> m_tdata[81:66] != 16'd0)
        else $error("step-ending status with zero steps");

endmodule

bind halley_polynomial_root_finder_core hprf_checker u_hprf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
